[rtl/vcoca_pkg.sv]
// Shared types for the VC output credit allocator: request codes, item, command and result structs.
package vcoca_pkg;

    typedef enum logic [1:0] {
        REQ_VC      = 2'd0,
        REQ_SWITCH  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_CREDIT  = 2'd3
    } req_kind_t;

    // Index width that covers every entry reachable through 3-bit port and 2-bit VC fields
    localparam int unsigned ENTRY_IDX_W = 5;

    typedef struct packed {
        req_kind_t   req_type;
        logic [1:0]  vc_id;
        logic [2:0]  dest_port;
        logic [2:0]  in_port;
        logic [3:0]  credit_amount;
    } item_t;

    typedef struct packed {
        logic                   hit;
        req_kind_t              kind;
        logic [ENTRY_IDX_W-1:0] idx;
        logic [2:0]             dest_port;
        logic [2:0]             in_port;
        logic [3:0]             amount;
    } cmd_t;

    typedef struct packed {
        logic       grant_valid;
        logic [2:0] grant_to_input;
        logic [2:0] grant_out_port;
        logic       protocol_error;
    } result_t;

endpackage

[rtl/vc_output_credit_allocator.sv]
// A request is written into the command queue, executed by the back end from its head, and its
// result is written into the result queue, from which it is popped.
// Throughput: one request per cycle while neither queue is full; the back end executes one
// command per cycle from a two-entry command queue into a two-entry result queue.
// Reset (rst_n low, asynchronous) clears both queues and sets every entry idle,
// with zero credits and owner zero.
// Top level: VC output credit allocator, front classifier, command queue, back end, result queue.
module vc_output_credit_allocator #(
    parameter int unsigned NUM_PORTS  = 8,
    parameter int unsigned NUM_VCS    = 4,
    parameter int unsigned CREDIT_MAX = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vcoca_pkg::item_t   item,
    input  logic               pop,
    output logic               empty,
    output vcoca_pkg::result_t result
);

    localparam int unsigned CMD_W = $bits(vcoca_pkg::cmd_t);
    localparam int unsigned RES_W = $bits(vcoca_pkg::result_t);

    vcoca_pkg::cmd_t    front_cmd;
    vcoca_pkg::cmd_t    back_cmd;
    vcoca_pkg::result_t back_res;
    logic               cmd_empty;
    logic               cmd_take;
    logic               res_full;
    logic               res_write;
    logic [CMD_W-1:0]   cmd_rd_data;
    logic [RES_W-1:0]   res_rd_data;

    vcoca_front #(
        .NUM_PORTS (NUM_PORTS),
        .NUM_VCS   (NUM_VCS)
    ) u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    vcoca_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign back_cmd = vcoca_pkg::cmd_t'(cmd_rd_data);

    vcoca_back #(
        .NUM_PORTS  (NUM_PORTS),
        .NUM_VCS    (NUM_VCS),
        .CREDIT_MAX (CREDIT_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (back_cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_write (res_write),
        .res       (back_res)
    );

    // hold finished results until the consumer takes the transfer
    vcoca_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = vcoca_pkg::result_t'(res_rd_data);

endmodule

[rtl/vcoca_fifo.sv]
// Small register queue with show-ahead head, used between the stages and at the result side.
module vcoca_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/vcoca_front.sv]
// Front end: range check and entry index for each incoming request.
module vcoca_front #(
    parameter int unsigned NUM_PORTS = 8,
    parameter int unsigned NUM_VCS   = 4
) (
    input  vcoca_pkg::item_t item,
    output vcoca_pkg::cmd_t  cmd
);

    // Only VCs 0..3 are reachable, so the table packs entries with that stride
    localparam int unsigned VC_EFF = (NUM_VCS < 4) ? NUM_VCS : 4;

    logic in_range;

    assign in_range = (int'(item.dest_port) < int'(NUM_PORTS))
                   && (int'(item.vc_id) < int'(NUM_VCS));

    always_comb
    begin
        cmd.hit       = in_range;
        cmd.kind      = item.req_type;
        cmd.idx       = vcoca_pkg::ENTRY_IDX_W'(int'(item.dest_port) * int'(VC_EFF)
                                                + int'(item.vc_id));
        cmd.dest_port = item.dest_port;
        cmd.in_port   = item.in_port;
        cmd.amount    = item.credit_amount;
    end

endmodule

[rtl/vcoca_back.sv]
// Back end: per-entry active, owner and credit state; executes one command and forms its result.
module vcoca_back #(
    parameter int unsigned NUM_PORTS  = 8,
    parameter int unsigned NUM_VCS    = 4,
    parameter int unsigned CREDIT_MAX = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  vcoca_pkg::cmd_t     cmd,
    output logic                cmd_take,
    input  logic                res_full,
    output logic                res_write,
    output vcoca_pkg::result_t  res
);

    localparam int unsigned PORT_EFF = (NUM_PORTS < 8) ? NUM_PORTS : 8;
    localparam int unsigned VC_EFF   = (NUM_VCS < 4) ? NUM_VCS : 4;
    localparam int unsigned ENTRIES  = PORT_EFF * VC_EFF;
    localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW       = $clog2(CREDIT_MAX + 1);
    localparam int unsigned SW       = ((CW > 4) ? CW : 4) + 1;

    logic          active_reg [ENTRIES];
    logic [CW-1:0] credit_reg [ENTRIES];
    logic [2:0]    owner_reg  [ENTRIES];

    logic [IDX_W-1:0] idx;
    logic             cur_active;
    logic [CW-1:0]    cur_credit;
    logic [2:0]       cur_owner;
    logic [SW-1:0]    credit_sum;
    logic             ent_wr;
    logic             active_next;
    logic [CW-1:0]    credit_next;
    logic [2:0]       owner_next;

    assign cmd_take   = cmd_valid && !res_full;
    assign res_write  = cmd_take;
    assign idx        = cmd.idx[IDX_W-1:0];
    assign cur_active = active_reg[idx];
    assign cur_credit = credit_reg[idx];
    assign cur_owner  = owner_reg[idx];
    assign credit_sum = SW'(cur_credit) + SW'(cmd.amount);

    always_comb
    begin
        res         = '0;
        ent_wr      = 1'b0;
        active_next = cur_active;
        credit_next = cur_credit;
        owner_next  = cur_owner;
        if (cmd.hit)
        begin
            unique case (cmd.kind) inside
                vcoca_pkg::REQ_CREDIT:
                begin
                    ent_wr      = 1'b1;
                    credit_next = (credit_sum > SW'(CREDIT_MAX)) ? CW'(CREDIT_MAX)
                                                                 : credit_sum[CW-1:0];
                end
                vcoca_pkg::REQ_VC:
                begin
                    if (cur_credit != '0 && !cur_active)
                    begin
                        ent_wr             = 1'b1;
                        active_next        = 1'b1;
                        owner_next         = cmd.in_port;
                        credit_next        = cur_credit - CW'(1);
                        res.grant_valid    = 1'b1;
                        res.grant_to_input = cmd.in_port;
                        res.grant_out_port = cmd.dest_port;
                    end
                end
                vcoca_pkg::REQ_SWITCH, vcoca_pkg::REQ_RELEASE:
                begin
                    // no credits: drop silently, ahead of the ownership check
                    if (cur_credit != '0)
                    begin
                        if (!cur_active || cur_owner != cmd.in_port)
                        begin
                            res.protocol_error = 1'b1;
                        end
                        else
                        begin
                            ent_wr             = 1'b1;
                            credit_next        = cur_credit - CW'(1);
                            res.grant_valid    = 1'b1;
                            res.grant_to_input = cur_owner;
                            res.grant_out_port = cmd.dest_port;
                            if (cmd.kind == vcoca_pkg::REQ_RELEASE)
                            begin
                                active_next = 1'b0;
                                owner_next  = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    ent_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < int'(ENTRIES); e++)
            begin
                active_reg[e] <= 1'b0;
                credit_reg[e] <= '0;
                owner_reg[e]  <= '0;
            end
        end
        else if (cmd_take && ent_wr)
        begin
            active_reg[idx] <= active_next;
            credit_reg[idx] <= credit_next;
            owner_reg[idx]  <= owner_next;
        end
    end

endmodule
